@@ sv/bvhq_pkg.sv @@
// Shared types and constants for the tree overlap query block.
// No dependencies; compiled first.
package bvhq_pkg;

	localparam int ADDR_W   = 10;
	localparam int COORD_W  = 32;
	localparam int LINK_W   = 17;
	localparam int HITS_W   = 6;
	localparam int NCOUNT_W = 11;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_NODE_COUNT = 1'b0;

	typedef struct packed {
		logic signed [COORD_W-1:0] lo_x;
		logic signed [COORD_W-1:0] lo_y;
		logic signed [COORD_W-1:0] lo_z;
		logic signed [COORD_W-1:0] hi_x;
		logic signed [COORD_W-1:0] hi_y;
		logic signed [COORD_W-1:0] hi_z;
		logic signed [LINK_W-1:0]  link;
	} node_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

endpackage

@@ sv/bvhq_cmd_if.sv @@
// Command channel: node loads and overlap queries.
// Depends on bvhq_pkg.
interface bvhq_cmd_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     command;
	logic [bvhq_pkg::ADDR_W-1:0]              node_addr;
	logic signed [bvhq_pkg::COORD_W-1:0]      min_x;
	logic signed [bvhq_pkg::COORD_W-1:0]      min_y;
	logic signed [bvhq_pkg::COORD_W-1:0]      min_z;
	logic signed [bvhq_pkg::COORD_W-1:0]      max_x;
	logic signed [bvhq_pkg::COORD_W-1:0]      max_y;
	logic signed [bvhq_pkg::COORD_W-1:0]      max_z;
	logic signed [bvhq_pkg::LINK_W-1:0]       link;
	logic [bvhq_pkg::HITS_W-1:0]              max_hits;

	modport source (output valid, command, node_addr, min_x, min_y, min_z,
		max_x, max_y, max_z, link, max_hits, input ready);
	modport sink (input valid, command, node_addr, min_x, min_y, min_z,
		max_x, max_y, max_z, link, max_hits, output ready);
endinterface

@@ sv/bvhq_rsp_if.sv @@
// Result channel: one beat per reported leaf, or one empty answer.
// Depends on bvhq_pkg.
interface bvhq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bvhq_pkg::ADDR_W-1:0]  leaf_node;
	logic                         found;
	logic [bvhq_pkg::HITS_W-1:0]  hit_number;
	logic                         last;

	modport source (output valid, leaf_node, found, hit_number, last, input ready);
	modport sink (input valid, leaf_node, found, hit_number, last, output ready);
endinterface

@@ sv/bvh_box_overlap_leaf_query.sv @@
// Top level of the tree overlap query: node store, walk sequencer, APB register.
// Depends on bvhq_pkg, bvhq_cmd_if, bvhq_rsp_if.
//
// Usage:
//   cmd carries loads (command 0: one node box plus link into slot node_addr)
//   and queries (command 1: query box plus max_hits). rsp carries one beat
//   per overlapping leaf, up to max_hits capped at HIT_LIMIT, in walk order,
//   the final one with last set; a query without hits gives one beat with found clear.
//   node_count is set over APB (byte address 0); the user writes it only while idle (not enforced by the block).
// Timing:
//   A load is written into the node store when accepted; cmd.ready stays high. A query
//   holds cmd.ready low until its final beat is pushed: the walk reads one node per cycle
//   from the node memory while no stall holds it, the next address taken from the
//   node just read. Up to NODE_DEPTH nodes are visited. A hit leaves the block when the
//   next hit is found or when the walk ends, so the last beat is sent from the flush
//   state after the walk.
// Reset clears the control state and node_count; the node store is not
// cleared and must be loaded before it is queried.
// A stalled receiver holds the output register; the walk pauses only when
// a second hit is waiting behind a full output register.
module bvh_box_overlap_leaf_query #(
	parameter int NODE_DEPTH = 1024,
	parameter int HIT_LIMIT  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	bvhq_cmd_if.sink                          cmd,
	bvhq_rsp_if.source                        rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bvhq_pkg::APB_AW-1:0]       paddr,
	input  logic [bvhq_pkg::APB_DW-1:0]       pwdata,
	output logic [bvhq_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);

	localparam int AW = $clog2(NODE_DEPTH);
	localparam int CW = $clog2(NODE_DEPTH + 1);
	localparam int LW = bvhq_pkg::LINK_W;
	localparam int SW = ((AW > LW) ? AW : LW) + 1;
	localparam int HW = bvhq_pkg::HITS_W;
	localparam int OW = bvhq_pkg::ADDR_W;
	localparam int NW = bvhq_pkg::NCOUNT_W;
	localparam int DW = bvhq_pkg::APB_DW;

	bvhq_pkg::state_t state_q;
	bvhq_pkg::node_t  mem [NODE_DEPTH];
	bvhq_pkg::node_t  rd_node_s1;
	bvhq_pkg::node_t  wr_node;

	logic [AW-1:0]  idx_q;
	logic [AW-1:0]  raddr;
	logic [HW-1:0]  limit_q;
	logic [HW-1:0]  lim;
	logic           p_valid_q;
	logic [AW-1:0]  p_leaf_q;
	logic [HW-1:0]  p_num_q;
	logic [NW-1:0]  node_count_q;
	logic [CW-1:0]  cnt;

	logic signed [bvhq_pkg::COORD_W-1:0] qlo_x_q, qlo_y_q, qlo_z_q;
	logic signed [bvhq_pkg::COORD_W-1:0] qhi_x_q, qhi_y_q, qhi_z_q;

	logic           o_valid_q;
	logic [OW-1:0]  o_leaf_q;
	logic           o_found_q;
	logic [HW-1:0]  o_num_q;
	logic           o_last_q;

	logic           cmd_acc, load_we, query_acc;
	logic           ov, leaf, hit, hit_final, walk_end, out_free, stall;
	logic           push_mid, push_fin;
	logic [LW-1:0]  skip;
	logic [SW-1:0]  step_sum;
	logic [HW-1:0]  hit_num;
	logic           cfg_we, reg_sel;

	// APB register
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_we  = psel && penable && pwrite && pready
		&& (reg_sel == bvhq_pkg::REG_NODE_COUNT);
	assign prdata  = (reg_sel == bvhq_pkg::REG_NODE_COUNT) ? DW'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_we) begin
			node_count_q <= pwdata[NW-1:0];
		end
	end

	always_comb begin
		if (32'(node_count_q) > NODE_DEPTH) begin
			cnt = CW'(NODE_DEPTH);
		end else begin
			cnt = CW'(node_count_q);
		end
	end

	// command decode
	assign cmd.ready = (state_q == bvhq_pkg::ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign load_we   = cmd_acc && (cmd.command == bvhq_pkg::CMD_LOAD)
		&& (32'(cmd.node_addr) < NODE_DEPTH);
	assign query_acc = cmd_acc && (cmd.command == bvhq_pkg::CMD_QUERY);
	assign lim = (32'(cmd.max_hits) > HIT_LIMIT) ? HW'(HIT_LIMIT) : cmd.max_hits;

	always_comb begin
		wr_node.lo_x = cmd.min_x;
		wr_node.lo_y = cmd.min_y;
		wr_node.lo_z = cmd.min_z;
		wr_node.hi_x = cmd.max_x;
		wr_node.hi_y = cmd.max_y;
		wr_node.hi_z = cmd.max_z;
		wr_node.link = cmd.link;
	end

	// node test on the word just read
	assign ov = ($signed(qlo_x_q) <= $signed(rd_node_s1.hi_x))
		&& ($signed(qhi_x_q) >= $signed(rd_node_s1.lo_x))
		&& ($signed(qlo_y_q) <= $signed(rd_node_s1.hi_y))
		&& ($signed(qhi_y_q) >= $signed(rd_node_s1.lo_y))
		&& ($signed(qlo_z_q) <= $signed(rd_node_s1.hi_z))
		&& ($signed(qhi_z_q) >= $signed(rd_node_s1.lo_z));
	assign leaf      = !rd_node_s1.link[LW-1];
	assign hit       = ov && leaf;
	assign skip      = ~rd_node_s1.link + LW'(1);
	assign step_sum  = SW'(idx_q) + ((ov || leaf) ? SW'(1) : SW'(skip));
	assign walk_end  = step_sum >= SW'(cnt);
	assign hit_num   = p_num_q + HW'(1);
	assign hit_final = hit && (hit_num == limit_q);
	assign out_free  = !o_valid_q || rsp.ready;
	assign stall     = (state_q == bvhq_pkg::ST_WALK) && hit && p_valid_q && !out_free;
	assign push_mid  = (state_q == bvhq_pkg::ST_WALK) && !stall && hit && p_valid_q;
	assign push_fin  = (state_q == bvhq_pkg::ST_FLUSH) && out_free;

	always_comb begin
		case (state_q)
			bvhq_pkg::ST_WALK: begin
				raddr = stall ? idx_q : step_sum[AW-1:0];
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	// node memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[AW'(cmd.node_addr)] <= wr_node;
		end
		rd_node_s1 <= mem[raddr];
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bvhq_pkg::ST_IDLE;
			idx_q     <= '0;
			p_valid_q <= 1'b0;
			p_num_q   <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (push_mid || push_fin) begin
				o_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				bvhq_pkg::ST_IDLE: begin
					if (query_acc) begin
						idx_q     <= '0;
						p_valid_q <= 1'b0;
						p_num_q   <= '0;
						if (lim == '0 || cnt == '0) begin
							state_q <= bvhq_pkg::ST_FLUSH;
						end else begin
							state_q <= bvhq_pkg::ST_WALK;
						end
					end
				end
				bvhq_pkg::ST_WALK: begin
					if (!stall) begin
						if (hit) begin
							p_valid_q <= 1'b1;
							p_num_q   <= hit_num;
						end
						if (hit_final || walk_end) begin
							state_q <= bvhq_pkg::ST_FLUSH;
						end else begin
							idx_q <= step_sum[AW-1:0];
						end
					end
				end
				bvhq_pkg::ST_FLUSH: begin
					if (out_free) begin
						p_valid_q <= 1'b0;
						state_q   <= bvhq_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= bvhq_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (query_acc) begin
			qlo_x_q <= cmd.min_x;
			qlo_y_q <= cmd.min_y;
			qlo_z_q <= cmd.min_z;
			qhi_x_q <= cmd.max_x;
			qhi_y_q <= cmd.max_y;
			qhi_z_q <= cmd.max_z;
			limit_q <= lim;
		end
		if ((state_q == bvhq_pkg::ST_WALK) && !stall && hit) begin
			p_leaf_q <= idx_q;
		end
		if (push_mid) begin
			o_leaf_q  <= OW'(p_leaf_q);
			o_found_q <= 1'b1;
			o_num_q   <= p_num_q;
			o_last_q  <= 1'b0;
		end else if (push_fin) begin
			o_leaf_q  <= p_valid_q ? OW'(p_leaf_q) : '0;
			o_found_q <= p_valid_q;
			o_num_q   <= p_valid_q ? p_num_q : '0;
			o_last_q  <= 1'b1;
		end
	end

	assign rsp.valid      = o_valid_q;
	assign rsp.leaf_node  = o_leaf_q;
	assign rsp.found      = o_found_q;
	assign rsp.hit_number = o_num_q;
	assign rsp.last       = o_last_q;

endmodule

@@ sv/bvhq_check.sv @@
// Port-level assertions for bvh_box_overlap_leaf_query, attached by bind.
// Depends on bvhq_pkg and the top level.
module bvhq_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic                         cmd_command,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [bvhq_pkg::ADDR_W-1:0]  rsp_leaf_node,
	input logic                         rsp_found,
	input logic [bvhq_pkg::HITS_W-1:0]  rsp_hit_number,
	input logic                         rsp_last
);

	// stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_leaf_node)
		&& $stable(rsp_found) && $stable(rsp_hit_number) && $stable(rsp_last))
		else $error("result beat changed while stalled");

	// an accepted query drops cmd_ready, blocking further commands
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_command == bvhq_pkg::CMD_QUERY) |=> !cmd_ready)
		else $error("command accepted during a query");

	// a load never blocks the channel
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_command == bvhq_pkg::CMD_LOAD) |=> cmd_ready)
		else $error("load held the command channel");

	// empty answer is a single final beat with zero fields
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_last && (rsp_hit_number == '0)
		&& (rsp_leaf_node == '0))
		else $error("malformed empty answer");

	// a found beat after an accepted non-final hit beat has a nonzero hit number
	a_first_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp_found && !rsp_last ##1 rsp_valid && rsp_found
		|-> rsp_hit_number != '0)
		else $error("hit beat without a hit number");

endmodule

bind bvh_box_overlap_leaf_query bvhq_check u_bvhq_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_command    (cmd.command),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_leaf_node  (rsp.leaf_node),
	.rsp_found      (rsp.found),
	.rsp_hit_number (rsp.hit_number),
	.rsp_last       (rsp.last)
);
